// ===== rtl/sbce_pkg.sv =====
// Shared types, opcodes and constants for the sixteen-bit execute core.
package sbce_pkg;

  localparam int unsigned DataWords = 65536;
  localparam int unsigned DataAw    = $clog2(DataWords);

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_AND  = 5'd2,
    OP_NOR  = 5'd3,
    OP_DIV  = 5'd4,
    OP_MUL  = 5'd5,
    OP_MOD  = 5'd6,
    OP_POW  = 5'd7,
    OP_LW   = 5'd8,
    OP_SW   = 5'd9,
    OP_JR   = 5'd12,
    OP_HALT = 5'd13,
    OP_PUT  = 5'd14,
    OP_LIZ  = 5'd16,
    OP_LIS  = 5'd17,
    OP_LUI  = 5'd18,
    OP_JALR = 5'd19,
    OP_BP   = 5'd20,
    OP_BN   = 5'd21,
    OP_BX   = 5'd22,
    OP_BZ   = 5'd23,
    OP_J    = 5'd24
  } opcode_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic decode;     // latch instruction, read register file
    logic start_div;  // start divide/modulo unit
    logic start_pow;  // start power unit
    logic step;       // one iteration of the active unit
    logic mem_rd;     // issue data store read
    logic commit;     // write back and load result register
    logic stop_only;  // commit a stopped-step result
  } sbce_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [4:0] opcode;
    logic       unit_done;
    logic       stopped;
    logic       pc_at_end;
  } sbce_sts_t;

endpackage

// ===== rtl/sbce_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface sbce_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sbce_datapath.sv =====
// Datapath: register file, PC, data store, divide and power units.
module sbce_datapath
  import sbce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sbce_cmd_t   cmd_i,
  output sbce_sts_t   sts_o,
  input  logic [15:0] instruction_i,
  input  logic [15:0] program_length_i,
  output logic [15:0] next_pc_o,
  output logic        halted_o,
  output logic        write_enable_o,
  output logic [2:0]  write_register_o,
  output logic [15:0] write_value_o,
  output logic        divide_by_zero_o
);

  logic [15:0] rf_q [8];
  logic [15:0] pc_q;
  logic        stopped_q;
  logic [15:0] ins_q, a_q, b_q, rdv_q;
  logic [15:0] mem [DataWords];
  logic [15:0] mem_rdata_q;

  // divider state
  logic [15:0] dquo_q, drem_q, ddiv_q;
  logic        dneg_q, rneg_q;
  // power state
  logic [15:0] acc_q, sq_q, pn_q;
  logic [31:0] pow_mul;
  logic [4:0]  cnt_q;

  logic [4:0] op;
  logic [2:0] rd;
  assign op = ins_q[15:11];
  assign rd = ins_q[10:8];

  logic [16:0] trial;
  assign trial = {drem_q, dquo_q[15]} - {1'b0, ddiv_q};

  assign sts_o.opcode    = op;
  assign sts_o.unit_done = (cnt_q == 5'd0);
  assign sts_o.stopped   = stopped_q;
  assign sts_o.pc_at_end = (pc_q >= program_length_i);

  // result computation
  logic        we, dz, hlt;
  logic [15:0] val, nxt, qv, rv;
  always_comb begin
    we = 1'b0; dz = 1'b0; hlt = 1'b0; val = '0;
    nxt = pc_q + 16'd1;
    qv = dneg_q ? (16'd0 - dquo_q) : dquo_q;
    rv = rneg_q ? (16'd0 - drem_q) : drem_q;
    case (op)
      OP_ADD:  begin we = 1'b1; val = a_q + b_q; end
      OP_SUB:  begin we = 1'b1; val = a_q - b_q; end
      OP_AND:  begin we = 1'b1; val = a_q & b_q; end
      OP_NOR:  begin we = 1'b1; val = ~(a_q | b_q); end
      OP_DIV:  begin we = 1'b1; dz = (b_q == 16'd0); val = dz ? 16'd0 : qv; end
      OP_MUL:  begin we = 1'b1; val = pow_mul[15:0]; end
      OP_MOD:  begin we = 1'b1; dz = (b_q == 16'd0); val = dz ? 16'd0 : rv; end
      OP_POW:  begin
        we = 1'b1;
        if (b_q[15]) begin
          if (a_q == 16'd1) val = 16'd1;
          else if (a_q == 16'hFFFF) val = b_q[0] ? 16'hFFFF : 16'd1;
          else val = 16'd0;
        end else begin
          val = acc_q;
        end
      end
      OP_LW:   begin we = 1'b1; val = mem_rdata_q; end
      OP_JR:   nxt = {a_q[15], a_q[15:1]};
      OP_HALT: hlt = 1'b1;
      OP_LIZ:  begin we = 1'b1; val = {8'd0, ins_q[7:0]}; end
      OP_LIS:  begin we = 1'b1; val = {{8{ins_q[7]}}, ins_q[7:0]}; end
      OP_LUI:  begin we = 1'b1; val = {ins_q[7:0], rdv_q[7:0]}; end
      OP_JALR: begin
        we  = 1'b1;
        val = {nxt[14:0], 1'b0};
        nxt = (rd == ins_q[7:5]) ? {val[15], val[15:1]} : {a_q[15], a_q[15:1]};
      end
      OP_BP:   if (!rdv_q[15] && rdv_q != 16'd0) nxt = {9'd0, ins_q[6:0]};
      OP_BN:   if (rdv_q[15]) nxt = {9'd0, ins_q[6:0]};
      OP_BX:   if (rdv_q != 16'd0) nxt = {9'd0, ins_q[6:0]};
      OP_BZ:   if (rdv_q == 16'd0) nxt = {9'd0, ins_q[6:0]};
      OP_J:    nxt = {pc_q[15:11], ins_q[10:0]};
      default: ;
    endcase
  end

  // multiplier shared by mul and power; registered operands on both sides
  logic [15:0] mx, my;
  always_comb begin
    if (op == OP_POW) begin
      mx = pn_q[0] ? acc_q : sq_q;
      my = sq_q;
    end else begin
      mx = a_q;
      my = b_q;
    end
  end
  assign pow_mul = mx * my;

  logic [31:0] sq_mul;
  assign sq_mul = sq_q * sq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) mem_rdata_q <= mem[a_q[DataAw-1:0]];
    if (cmd_i.commit && !cmd_i.stop_only && op == OP_SW) mem[a_q[DataAw-1:0]] <= b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
      pc_q <= '0; stopped_q <= 1'b0; cnt_q <= '0;
      ins_q <= '0; a_q <= '0; b_q <= '0; rdv_q <= '0;
      dneg_q <= 1'b0; rneg_q <= 1'b0; dquo_q <= '0; ddiv_q <= '0; drem_q <= '0;
      acc_q <= '0; sq_q <= '0; pn_q <= '0;
      next_pc_o <= '0; halted_o <= 1'b0; write_enable_o <= 1'b0;
      write_register_o <= '0; write_value_o <= '0; divide_by_zero_o <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        ins_q <= instruction_i;
        a_q   <= rf_q[instruction_i[7:5]];
        b_q   <= rf_q[instruction_i[4:2]];
        rdv_q <= rf_q[instruction_i[10:8]];
      end
      if (cmd_i.start_div) begin
        dneg_q <= a_q[15] ^ b_q[15];
        rneg_q <= a_q[15];
        dquo_q <= a_q[15] ? 16'd0 - a_q : a_q;
        ddiv_q <= b_q[15] ? 16'd0 - b_q : b_q;
        drem_q <= '0;
        cnt_q  <= 5'd16;
      end
      if (cmd_i.start_pow) begin
        acc_q <= 16'd1; sq_q <= a_q; pn_q <= b_q; cnt_q <= 5'd16;
      end
      if (cmd_i.step && cnt_q != 5'd0) begin
        cnt_q <= cnt_q - 5'd1;
        if (op == OP_POW) begin
          if (pn_q[0]) acc_q <= pow_mul[15:0];
          sq_q <= sq_mul[15:0];
          pn_q <= {1'b0, pn_q[15:1]};
        end else begin
          if (!trial[16]) begin
            drem_q <= trial[15:0];
            dquo_q <= {dquo_q[14:0], 1'b1};
          end else begin
            drem_q <= {drem_q[14:0], dquo_q[15]};
            dquo_q <= {dquo_q[14:0], 1'b0};
          end
        end
      end
      if (cmd_i.stop_only) begin
        stopped_q <= 1'b1;
        next_pc_o <= pc_q; halted_o <= 1'b1; write_enable_o <= 1'b0;
        write_register_o <= '0; write_value_o <= '0; divide_by_zero_o <= 1'b0;
      end else if (cmd_i.commit) begin
        if (we) rf_q[rd] <= val;
        pc_q <= nxt;
        stopped_q <= hlt || (nxt >= program_length_i);
        next_pc_o <= nxt;
        halted_o <= hlt || (nxt >= program_length_i);
        write_enable_o <= we;
        write_register_o <= we ? rd : 3'd0;
        write_value_o <= we ? val : 16'd0;
        divide_by_zero_o <= dz;
      end
    end
  end

endmodule

// ===== rtl/sbce_ctrl.sv =====
// Controller state machine: sequences decode, unit iterations and write-back.
module sbce_ctrl
  import sbce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sbce_cmd_t cmd_o,
  input  sbce_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_ITER, S_MEM, S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  // Next item may enter once the previous result is taken or is being taken.
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.decode = accept;
    case (state_q)
      S_DECODE: begin
        if (!(sts_i.stopped || sts_i.pc_at_end)) begin
          cmd_o.start_div = (sts_i.opcode == OP_DIV) || (sts_i.opcode == OP_MOD);
          cmd_o.start_pow = (sts_i.opcode == OP_POW);
          cmd_o.mem_rd    = (sts_i.opcode == OP_LW);
        end
      end
      S_ITER:   cmd_o.step = 1'b1;
      S_COMMIT: begin
        cmd_o.commit    = 1'b1;
        cmd_o.stop_only = sts_i.stopped || sts_i.pc_at_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE:   if (accept) state_q <= S_DECODE;
        S_DECODE: begin
          if (sts_i.stopped || sts_i.pc_at_end) state_q <= S_COMMIT;
          else if (sts_i.opcode == OP_DIV || sts_i.opcode == OP_MOD ||
                   sts_i.opcode == OP_POW) state_q <= S_ITER;
          else if (sts_i.opcode == OP_LW) state_q <= S_MEM;
          else state_q <= S_COMMIT;
        end
        S_ITER:   if (sts_i.unit_done) state_q <= S_COMMIT;
        S_MEM:    state_q <= S_COMMIT;
        S_COMMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_commit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |=> out_valid_q) else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("accept while busy");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.start_div && cmd_o.start_pow)) else $error("two units started");
`endif

endmodule

// ===== rtl/sixteen_bit_core_execute.sv =====
// Top level of the sixteen-bit execute core: controller plus datapath.
//
//  channel   | dir | payload                                   | transaction
//  ----------+-----+-------------------------------------------+----------------
//  in_ch     | in  | instruction[15:0]                         | one instruction
//  out_ch    | out | next_pc, halted, write_enable, write_reg, | one result
//            |     | write_value, divide_by_zero               |
//  cfg_ch    | in  | program_length[15:0]                      | register write
//
//  Each transaction passes decode and commit; loads add a registered data
//  store read, and div, mod and power add 16 iterations of the radix-2
//  divider or the square-and-multiply unit before commit.
//  Reset clears registers, PC and the stopped flag; the data store is not
//  cleared. A stalled result holds in the output register; the next
//  instruction is taken in the cycle that result leaves.
module sixteen_bit_core_execute
  import sbce_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  sbce_stream_if.sink   in_ch,
  sbce_stream_if.source out_ch,
  sbce_stream_if.sink   cfg_ch
);

  sbce_cmd_t   cmd;
  sbce_sts_t   sts;
  logic [15:0] plen_q;

  // Config is to be written only while idle; the block does not enforce it. Always ready.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) plen_q <= '0;
    else if (cfg_ch.valid) plen_q <= cfg_ch.data;
  end

  sbce_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sbce_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .instruction_i    (in_ch.data),
    .program_length_i (plen_q),
    .next_pc_o        (out_ch.data.next_pc),
    .halted_o         (out_ch.data.halted),
    .write_enable_o   (out_ch.data.write_enable),
    .write_register_o (out_ch.data.write_register),
    .write_value_o    (out_ch.data.write_value),
    .divide_by_zero_o (out_ch.data.divide_by_zero)
  );

endmodule

// ===== sim/sbce_tb_pkg.sv =====
`timescale 1ns / 1ps
// Result transaction layout shared by the execute-core testbench files.
package sbce_tb_pkg;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        write_enable;
    logic [2:0]  write_register;
    logic [15:0] write_value;
    logic        divide_by_zero;
  } exec_result_t;

endpackage

// ===== sim/sixteen_bit_core_execute_checker.sv =====
`timescale 1ns / 1ps
// Execute-core checker: predicts each result and compares it with the block's output.
module sixteen_bit_core_execute_checker
  import sbce_pkg::*;
  import sbce_tb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         instr_valid_i,
  input  logic         instr_ready_i,
  input  logic [15:0]  instr_data_i,
  input  logic         res_valid_i,
  input  logic         res_ready_i,
  input  exec_result_t res_data_i,
  input  logic         len_valid_i,
  input  logic         len_ready_i,
  input  logic [15:0]  len_data_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  logic [15:0]  regs [8];
  logic [15:0]  pc;
  logic         halted_q;
  logic [15:0]  prog_len;
  logic [15:0]  data_words [int unsigned];
  exec_result_t results_due [$];
  int unsigned  fails;

  assign fail_count_o = fails;
  assign pending_o    = results_due.size();

  initial fails = 0;

  function automatic logic [15:0] half_word(input logic [15:0] v);
    return {v[15], v[15:1]};
  endfunction

  function automatic logic [15:0] raise16(input logic [15:0] b, input logic [15:0] e);
    logic [15:0] acc;
    logic [15:0] sq;
    logic [15:0] n;
    if (e[15]) begin
      if (b == 16'h0001) return 16'h0001;
      if (b == 16'hFFFF) return e[0] ? 16'hFFFF : 16'h0001;
      return 16'h0000;
    end
    acc = 16'h0001;
    sq  = b;
    n   = e;
    while (n != 0) begin
      if (n[0]) acc = acc * sq;
      sq = sq * sq;
      n  = n >> 1;
    end
    return acc;
  endfunction

  task automatic execute(input logic [15:0] ins, output exec_result_t r);
    logic [2:0]  rd;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] nxt;
    logic [15:0] val;
    logic        we;
    logic        dz;
    logic        hlt;
    int          sa;
    int          sb;
    rd  = ins[10:8];
    a   = regs[ins[7:5]];
    b   = regs[ins[4:2]];
    sa  = $signed(a);
    sb  = $signed(b);
    nxt = pc + 16'd1;
    val = '0;
    we  = 1'b0;
    dz  = 1'b0;
    hlt = 1'b0;
    r   = '0;
    if (halted_q || pc >= prog_len) begin
      halted_q  = 1'b1;
      r.next_pc = pc;
      r.halted  = 1'b1;
      return;
    end
    case (opcode_e'(ins[15:11]))
      OP_ADD: begin we = 1; val = a + b; end
      OP_SUB: begin we = 1; val = a - b; end
      OP_AND: begin we = 1; val = a & b; end
      OP_NOR: begin we = 1; val = ~(a | b); end
      OP_DIV: begin
        we = 1;
        if (sb == 0) dz = 1;
        else val = 16'(sa / sb);
      end
      OP_MUL: begin we = 1; val = a * b; end
      OP_MOD: begin
        we = 1;
        if (sb == 0) dz = 1;
        else val = 16'(sa % sb);
      end
      OP_POW: begin we = 1; val = raise16(a, b); end
      OP_LW: begin
        we  = 1;
        val = data_words.exists(a) ? data_words[a] : 16'h0000;
      end
      OP_SW:   data_words[a] = b;
      OP_JR:   nxt = half_word(a);
      OP_HALT: hlt = 1;
      OP_LIZ: begin we = 1; val = {8'h00, ins[7:0]}; end
      OP_LIS: begin we = 1; val = {{8{ins[7]}}, ins[7:0]}; end
      OP_LUI: begin we = 1; val = {ins[7:0], regs[rd][7:0]}; end
      OP_JALR: begin
        // link is written before the source is read
        we       = 1;
        val      = {nxt[14:0], 1'b0};
        regs[rd] = val;
        nxt      = half_word(regs[ins[7:5]]);
      end
      OP_BP: if ($signed(regs[rd]) > 0) nxt = {9'd0, ins[6:0]};
      OP_BN: if ($signed(regs[rd]) < 0) nxt = {9'd0, ins[6:0]};
      OP_BX: if (regs[rd] != 0) nxt = {9'd0, ins[6:0]};
      OP_BZ: if (regs[rd] == 0) nxt = {9'd0, ins[6:0]};
      OP_J:  nxt = {pc[15:11], ins[10:0]};
      default: ;
    endcase
    if (we) regs[rd] = val;
    pc = nxt;
    if (hlt || nxt >= prog_len) halted_q = 1'b1;
    r.next_pc        = nxt;
    r.halted         = halted_q;
    r.write_enable   = we;
    r.write_register = we ? rd : 3'd0;
    r.write_value    = we ? val : 16'h0000;
    r.divide_by_zero = dz;
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    fails++;
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exec_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs[i] = '0;
      pc       = '0;
      halted_q = 1'b0;
      prog_len = '0;
      results_due.delete();
    end else begin
      if (len_valid_i && len_ready_i) prog_len = len_data_i;
      // result first: it belongs to an older instruction than one taken now
      if (res_valid_i && res_ready_i) begin
        if (results_due.size() == 0) begin
          report("unexpected result, next_pc", res_data_i.next_pc, 16'h0000);
        end else begin
          want = results_due.pop_front();
          if (res_data_i.next_pc != want.next_pc)
            report("next_pc", res_data_i.next_pc, want.next_pc);
          if (res_data_i.halted != want.halted)
            report("halted", res_data_i.halted, want.halted);
          if (res_data_i.write_enable != want.write_enable)
            report("write_enable", res_data_i.write_enable, want.write_enable);
          if (res_data_i.write_register != want.write_register)
            report("write_register", res_data_i.write_register, want.write_register);
          if (res_data_i.write_value != want.write_value)
            report("write_value", res_data_i.write_value, want.write_value);
          if (res_data_i.divide_by_zero != want.divide_by_zero)
            report("divide_by_zero", res_data_i.divide_by_zero, want.divide_by_zero);
        end
      end
      if (instr_valid_i && instr_ready_i) begin
        execute(instr_data_i, want);
        results_due.push_back(want);
      end
    end
  end

endmodule

// ===== sim/sixteen_bit_core_execute_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the execute core: stimulus, handshake pressure and verdict.
module sixteen_bit_core_execute_tb;
  import sbce_pkg::*;
  import sbce_tb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomInstrs = 660;
  // scratch register used to build data-store addresses
  localparam logic [2:0] AddrReg = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sbce_stream_if #(.payload_t(logic [15:0])) in_ch ();
  sbce_stream_if #(.payload_t(exec_result_t)) out_ch ();
  sbce_stream_if #(.payload_t(logic [15:0])) cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent;
  int unsigned received;
  int unsigned cycles;
  int unsigned burst_left;
  bit          hold_request;
  logic [15:0] stored_addrs [$];

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  sixteen_bit_core_execute u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sixteen_bit_core_execute_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .instr_valid_i (in_ch.valid),
    .instr_ready_i (in_ch.ready),
    .instr_data_i  (in_ch.data),
    .res_valid_i   (out_ch.valid),
    .res_ready_i   (out_ch.ready),
    .res_data_i    (out_ch.data),
    .len_valid_i   (cfg_ch.valid),
    .len_ready_i   (cfg_ch.ready),
    .len_data_i    (cfg_ch.data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog; also counts result transactions.
  initial begin
    cycles   = 0;
    received = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (out_ch.valid && out_ch.ready) received++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: mostly-ready pattern with stall runs, plus one long hold-off
  // when the stimulus asks for it so the core backs up into its input.
  initial begin
    int unsigned mode;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_request = 1'b0;
      end
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 40)) @(posedge clk_i);
      end else if (mode < 9) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 25)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [15:0] enc_reg(input opcode_e op, input logic [2:0] rd,
                                          input logic [2:0] rs, input logic [2:0] rt);
    return {op, rd, rs, rt, 2'($urandom)};
  endfunction

  function automatic logic [15:0] enc_imm(input opcode_e op, input logic [2:0] rd,
                                          input logic [7:0] imm);
    return {op, rd, imm};
  endfunction

  // One instruction transaction. Valid stays high across a burst; a gap
  // lowers it once, after acceptance.
  task automatic issue(input logic [15:0] word);
    in_ch.valid <= 1'b1;
    in_ch.data  <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (received != sent) @(posedge clk_i);
    // every instruction yields a result, so a few cycles are plenty
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [15:0] len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load a full 16-bit constant via zero-extend plus load-upper.
  task automatic load_const(input logic [2:0] rd, input logic [15:0] v);
    issue(enc_imm(OP_LIZ, rd, v[7:0]));
    issue(enc_imm(OP_LUI, rd, v[15:8]));
  endtask

  task automatic store_word(input logic [15:0] addr, input logic [2:0] rt);
    load_const(AddrReg, addr);
    issue(enc_reg(OP_SW, 3'd0, AddrReg, rt));
    stored_addrs.push_back(addr);
  endtask

  // Loads only ever target a word that has been stored before.
  task automatic load_word(input logic [2:0] rd);
    logic [15:0] addr;
    addr = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
    load_const(AddrReg, addr);
    issue(enc_reg(OP_LW, rd, AddrReg, 3'($urandom)));
  endtask

  // Random instruction: any opcode except load and halt, random fields.
  function automatic logic [15:0] random_instr();
    logic [15:0] w;
    do begin
      w = 16'($urandom);
    end while (w[15:11] == OP_LW || w[15:11] == OP_HALT);
    return w;
  endfunction

  initial begin
    int unsigned pick;
    sent         = 0;
    burst_left   = 0;
    hold_request = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Longest program first, so execution runs through the bulk of the test.
    set_length(16'hFFFF);

    // Directed: extreme operands, most operations, the awkward arithmetic.
    load_const(3'd1, 16'h8000);                  // most negative
    issue(enc_imm(OP_LIS, 3'd2, 8'hFF));         // -1 by sign extension
    issue(enc_imm(OP_LIZ, 3'd3, 8'h00));         // zero
    issue(enc_imm(OP_LIS, 3'd4, 8'h7F));
    issue(enc_reg(OP_DIV, 3'd5, 3'd1, 3'd2));    // overflowing quotient
    issue(enc_reg(OP_MOD, 3'd5, 3'd1, 3'd2));
    issue(enc_reg(OP_DIV, 3'd5, 3'd4, 3'd3));    // zero divisor
    issue(enc_reg(OP_MOD, 3'd6, 3'd1, 3'd3));
    issue(enc_reg(OP_POW, 3'd5, 3'd3, 3'd3));    // zero to the zero
    issue(enc_reg(OP_POW, 3'd5, 3'd2, 3'd2));    // negative exponent, base -1
    issue(enc_reg(OP_POW, 3'd6, 3'd4, 3'd4));
    issue(enc_reg(OP_ADD, 3'd6, 3'd1, 3'd2));
    issue(enc_reg(OP_SUB, 3'd6, 3'd3, 3'd1));
    issue(enc_reg(OP_AND, 3'd6, 3'd1, 3'd2));
    issue(enc_reg(OP_NOR, 3'd6, 3'd3, 3'd3));
    issue(enc_reg(OP_MUL, 3'd6, 3'd1, 3'd2));
    store_word(16'hFFFF, 3'd1);
    store_word(16'h0000, 3'd2);
    load_word(3'd0);
    issue(enc_imm(OP_PUT, 3'd7, 8'hFF));
    issue(enc_reg(OP_JALR, 3'd4, 3'd4, 3'd0));   // link overwrites the source
    issue(enc_imm(OP_BN, 3'd1, 8'hFF));
    issue(enc_imm(OP_BZ, 3'd3, 8'h10));
    issue(16'hC7FF);                             // region jump, all offset bits set

    // Random: stores and loads in well-formed groups, the rest free-form.
    for (int i = 0; i < RandomInstrs; i++) begin
      if (i == 300) hold_request = 1'b1;         // long receiver hold-off
      if (i == 500) drain();                     // sender pause until all back
      pick = $urandom_range(0, 19);
      if (pick == 0) store_word(16'($urandom), 3'($urandom));
      else if (pick == 1) load_word(3'($urandom));
      else issue(random_instr());
    end
    drain();

    // Mid-range length followed by halt and stopped steps, then zero with stopped steps.
    set_length(16'd40000);
    repeat (10) issue(random_instr());
    issue(enc_imm(OP_HALT, 3'($urandom), 8'($urandom)));
    repeat (4) issue(random_instr());
    drain();
    set_length(16'h0000);
    repeat (6) issue(random_instr());
    drain();

    repeat (40) @(posedge clk_i);
    $display("run covered %0d instructions and %0d results over %0d cycles,",
             sent, received, cycles);
    $display("with program lengths 65535, 40000 and 0, halt and stopped steps");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sixteen_bit_core_execute.f =====
rtl/sbce_pkg.sv
rtl/sbce_stream_if.sv
rtl/sbce_datapath.sv
rtl/sbce_ctrl.sv
rtl/sixteen_bit_core_execute.sv
sim/sbce_tb_pkg.sv
sim/sixteen_bit_core_execute_checker.sv
sim/sixteen_bit_core_execute_tb.sv
